### rtl/tsdma_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tsdma_pkg
// Shared types, constants and the scratchpad decode for the temperature
// decode / moving average block.
// ----------------------------------------------------------------------------
package tsdma_pkg;

  localparam int SAMPLE_W = 16;
  localparam int MEAN_W   = 20;
  localparam int WLEN_W   = 5;
  localparam logic [WLEN_W-1:0] WLEN_RESET = 5'd4;

  // Resolution select, bits 6..5 of the configuration byte
  localparam logic [1:0] RES_9BIT  = 2'b00;
  localparam logic [1:0] RES_10BIT = 2'b01;
  localparam logic [1:0] RES_11BIT = 2'b10;
  localparam logic [1:0] RES_12BIT = 2'b11;

  // Per-cycle control fanned out to every cell of the sample chain
  typedef struct packed {
    logic shift;  // cell takes new data this cycle
    logic fill;   // take the broadcast sample instead of the neighbor
  } tsdma_cell_ctrl_t;

  // Raw two-byte reading with the undefined low bits cleared
  function automatic logic signed [SAMPLE_W-1:0] decode_sample(
    input logic [7:0] lo,
    input logic [7:0] hi,
    input logic [7:0] res
  );
    logic [SAMPLE_W-1:0] raw;
    raw = {hi, lo};
    case (res[6:5])
      RES_9BIT:  raw[2:0] = 3'b000;
      RES_10BIT: raw[1:0] = 2'b00;
      RES_11BIT: raw[0]   = 1'b0;
      RES_12BIT: raw      = raw;
      default:   raw      = raw;
    endcase
    return $signed(raw);
  endfunction

endpackage
`default_nettype wire

### rtl/tsdma_cell.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tsdma_cell
// One stage of the sample chain: holds one reading, passes it on.
// ----------------------------------------------------------------------------
module tsdma_cell
  import tsdma_pkg::*;
(
  input  wire logic                       clk,
  input  wire tsdma_cell_ctrl_t           ctrl,
  input  wire logic signed [SAMPLE_W-1:0] prev_data,
  input  wire logic signed [SAMPLE_W-1:0] fill_data,
  output logic signed [SAMPLE_W-1:0]      data
);

  logic signed [SAMPLE_W-1:0] data_r;
  logic signed [SAMPLE_W-1:0] data_nxt;

  always_comb begin
    data_nxt = data_r;
    if (ctrl.shift) begin
      data_nxt = ctrl.fill ? fill_data : prev_data;
    end
  end

  always_ff @(posedge clk) begin
    data_r <= data_nxt;
  end

  assign data = data_r;

endmodule
`default_nettype wire

### rtl/tsdma_div.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tsdma_div
// Unsigned restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module tsdma_div #(
  parameter int NUM_W = 25,
  parameter int DEN_W = 5
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             start,
  input  wire logic [NUM_W-1:0] num,
  input  wire logic [DEN_W-1:0] den,
  output logic                  q_valid,
  output logic [NUM_W-1:0]      quot
);

  localparam int CNT_W = (NUM_W > 1) ? $clog2(NUM_W) : 1;

  logic [NUM_W-1:0] quo_r, quo_nxt;
  logic [DEN_W-1:0] rem_r, rem_nxt;
  logic [DEN_W-1:0] den_r, den_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             busy_r, busy_nxt;
  logic             valid_r, valid_nxt;
  logic [DEN_W:0]   trial;
  logic [DEN_W:0]   diff;
  logic             qbit;

  always_comb begin
    trial = {rem_r, quo_r[NUM_W-1]};
    diff  = trial - {1'b0, den_r};
    qbit  = (trial >= {1'b0, den_r});

    quo_nxt   = quo_r;
    rem_nxt   = rem_r;
    den_nxt   = den_r;
    cnt_nxt   = cnt_r;
    busy_nxt  = busy_r;
    valid_nxt = valid_r;

    if (start) begin
      quo_nxt   = num;
      rem_nxt   = '0;
      den_nxt   = den;
      cnt_nxt   = CNT_W'(NUM_W - 1);
      busy_nxt  = 1'b1;
      valid_nxt = 1'b0;
    end else if (busy_r) begin
      quo_nxt = {quo_r[NUM_W-2:0], qbit};
      rem_nxt = qbit ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
      if (cnt_r == '0) begin
        busy_nxt  = 1'b0;
        valid_nxt = 1'b1;
      end else begin
        cnt_nxt = cnt_r - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r  <= 1'b0;
      valid_r <= 1'b0;
    end else begin
      busy_r  <= busy_nxt;
      valid_r <= valid_nxt;
    end
    quo_r <= quo_nxt;
    rem_r <= rem_nxt;
    den_r <= den_nxt;
    cnt_r <= cnt_nxt;
  end

  assign q_valid = valid_r;
  assign quot    = quo_r;

endmodule
`default_nettype wire

### rtl/temp_sensor_decode_moving_average.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// temp_sensor_decode_moving_average
// Decodes thermometer scratchpad bytes to a 1/16 degree reading and reports
// it with the mean of the most recent window_length readings (1/256 degree).
// ----------------------------------------------------------------------------
//  channel  dir  handshake              payload
//  in_      in   in_tvalid/in_tready    low byte, high byte, resolution byte
//  out_     out  out_tvalid/out_tready  sample_sixteenths, mean_256ths
//  cfg_     in   APB, pready tied high  reg 0 @ 0x0: window_length
//
// One transaction at a time. The new reading shifts in at the accepting edge.
// After it the sample chain rotates a full turn (the sum pass), the divider
// is started, the bit-serial divider produces the quotient and the result
// register is loaded; only then is the next transaction accepted.
// Reset (sync, active low) clears control, window_length to 4, not primed.
// A result waiting on out_tready holds the divider result; input is taken
// again as soon as the result moves into the output register.
// ----------------------------------------------------------------------------
module temp_sensor_decode_moving_average
  import tsdma_pkg::*;
#(
  parameter int MAX_WINDOW = 16
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  // input stream
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [23:0] in_tdata,     // [7:0] temp_low_byte, [15:8] temp_high_byte,
                                         // [23:16] resolution_byte
  // result stream
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [39:0]      out_tdata,    // [15:0] sample_sixteenths, [35:16] mean_256ths,
                                         // [39:36] zero
  // configuration
  input  wire logic        cfg_psel,
  input  wire logic        cfg_penable,
  input  wire logic        cfg_pwrite,
  input  wire logic [2:0]  cfg_paddr,
  input  wire logic [31:0] cfg_pwdata,
  output logic [31:0]      cfg_prdata,
  output logic             cfg_pready
);

  // Window length cannot exceed what the 5-bit register can express
  localparam int LEN_MAX = (MAX_WINDOW < 31) ? MAX_WINDOW : 31;
  localparam int LEN_W   = $clog2(LEN_MAX + 1);
  localparam int SUM_W   = SAMPLE_W + LEN_W;
  localparam int NUM_W   = SUM_W + 4;             // numerator is 16 * sum
  localparam int CNT_W   = $clog2(MAX_WINDOW + 1);
  localparam int CMP_W   = (CNT_W > LEN_W) ? CNT_W : LEN_W;

  typedef enum logic [1:0] {
    S_IDLE,
    S_ROT,
    S_START,
    S_DIV
  } state_t;

  state_t                     state_r;
  logic [WLEN_W-1:0]          wlen_r;
  logic                       primed_r;
  logic [CNT_W-1:0]           rot_cnt_r;
  logic signed [SUM_W-1:0]    sum_r;
  logic signed [SAMPLE_W-1:0] sample_r;
  logic                       neg_r;
  logic                       out_valid_r;
  logic signed [SAMPLE_W-1:0] out_sample_r;
  logic [MEAN_W-1:0]          out_mean_r;

  logic                       in_accept;
  logic                       cfg_write;
  logic signed [SAMPLE_W-1:0] sample_dec;
  logic [LEN_W-1:0]           len_eff;
  logic                       rot_last;
  logic                       rot_take;
  logic [SUM_W-1:0]           sum_abs;
  logic                       div_start;
  logic                       div_valid;
  logic [NUM_W-1:0]           div_quot;
  logic [NUM_W-1:0]           mean_full;
  logic                       out_free;
  logic                       out_load;

  tsdma_cell_ctrl_t           cell_ctrl;
  logic signed [SAMPLE_W-1:0] head_in;
  logic signed [SAMPLE_W-1:0] cell_q [MAX_WINDOW];

  // ---------------- configuration ----------------
  assign cfg_pready = 1'b1;
  assign cfg_write  = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;
  assign cfg_prdata = (cfg_paddr[2] == 1'b0) ? {{(32-WLEN_W){1'b0}}, wlen_r} : '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wlen_r <= WLEN_RESET;
    end else if (cfg_write && cfg_paddr[2] == 1'b0) begin
      wlen_r <= cfg_pwdata[WLEN_W-1:0];
    end
  end

  // zero counts as one, anything past the chain saturates
  always_comb begin
    if (wlen_r == '0) begin
      len_eff = LEN_W'(1);
    end else if (wlen_r > WLEN_W'(LEN_MAX)) begin
      len_eff = LEN_W'(LEN_MAX);
    end else begin
      len_eff = LEN_W'(wlen_r);
    end
  end

  // ---------------- sample chain ----------------
  // Cell 0 holds the newest reading, cell k the k-th older one. On accept the
  // chain shifts the new reading in (or every cell takes it on the very first
  // transaction). During the sum pass the chain rotates a full turn, so the
  // last cell presents each reading once, oldest first, and the chain ends
  // where it started. The newest len_eff readings come in the final counts.
  assign in_accept  = in_tvalid && in_tready;
  assign sample_dec = decode_sample(in_tdata[7:0], in_tdata[15:8], in_tdata[23:16]);

  assign cell_ctrl.shift = in_accept || (state_r == S_ROT);
  assign cell_ctrl.fill  = in_accept && !primed_r;
  assign head_in = (state_r == S_ROT) ? cell_q[MAX_WINDOW-1] : sample_dec;

  for (genvar k = 0; k < MAX_WINDOW; k++) begin : g_chain
    if (k == 0) begin : g_head
      tsdma_cell u_cell (
        .clk       (clk),
        .ctrl      (cell_ctrl),
        .prev_data (head_in),
        .fill_data (sample_dec),
        .data      (cell_q[k])
      );
    end else begin : g_body
      tsdma_cell u_cell (
        .clk       (clk),
        .ctrl      (cell_ctrl),
        .prev_data (cell_q[k-1]),
        .fill_data (sample_dec),
        .data      (cell_q[k])
      );
    end
  end

  assign rot_last = (rot_cnt_r == CNT_W'(MAX_WINDOW - 1));
  assign rot_take = (CMP_W'(rot_cnt_r) >= (CMP_W'(MAX_WINDOW) - CMP_W'(len_eff)));

  // ---------------- mean: |16 * sum| / len, sign restored ----------------
  assign sum_abs   = sum_r[SUM_W-1] ? (~sum_r + 1'b1) : sum_r;
  assign div_start = (state_r == S_START);

  tsdma_div #(
    .NUM_W (NUM_W),
    .DEN_W (LEN_W)
  ) u_div (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (div_start),
    .num     ({sum_abs, 4'b0000}),
    .den     (len_eff),
    .q_valid (div_valid),
    .quot    (div_quot)
  );

  assign mean_full = neg_r ? (~div_quot + 1'b1) : div_quot;
  assign out_free  = !out_valid_r || out_tready;
  assign out_load  = (state_r == S_DIV) && div_valid && out_free;

  // ---------------- control ----------------
  assign in_tready = (state_r == S_IDLE);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      primed_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        S_IDLE: begin
          if (in_accept) begin
            primed_r  <= 1'b1;
            sample_r  <= sample_dec;
            rot_cnt_r <= '0;
            sum_r     <= '0;
            state_r   <= S_ROT;
          end
        end
        S_ROT: begin
          if (rot_take) begin
            sum_r <= sum_r + SUM_W'(cell_q[MAX_WINDOW-1]);
          end
          rot_cnt_r <= rot_cnt_r + 1'b1;
          if (rot_last) begin
            state_r <= S_START;
          end
        end
        S_START: begin
          neg_r   <= sum_r[SUM_W-1];
          state_r <= S_DIV;
        end
        S_DIV: begin
          if (out_load) begin
            out_sample_r <= sample_r;
            out_mean_r   <= mean_full[MEAN_W-1:0];
            state_r      <= S_IDLE;
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {4'b0000, out_mean_r, out_sample_r};

  // ---------------- assertions ----------------
  a_accept_starts_pass: assert property (@(posedge clk) disable iff (!rst_n)
    in_accept |=> (state_r == S_ROT) && (rot_cnt_r == '0) && primed_r)
    else $error("accepted transaction did not start the sum pass");

  a_pass_full_turn: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_ROT) && !rot_last |=> (state_r == S_ROT))
    else $error("sum pass left before a full chain rotation");

  a_div_restarts: assert property (@(posedge clk) disable iff (!rst_n)
    div_start |=> !div_valid && (state_r == S_DIV))
    else $error("divider result visible right after start");

  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !out_tready |=> out_valid_r && $stable(out_mean_r))
    else $error("pending result lost or overwritten");

endmodule
`default_nettype wire

### sim/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for temp_sensor_decode_moving_average: drives scratchpad
// bytes on the input stream, rewrites window_length over APB between phases,
// and checks every result against an in-bench decoder / moving-average model.
// ----------------------------------------------------------------------------
module tb_top;
  import tsdma_pkg::*;

  localparam int RING_DEPTH   = 16;
  localparam int CLK_HALF_NS  = 4;
  localparam int RESET_CYCLES = 10;
  localparam int IDLE_CYCLES  = 8;      // block is idle once its result is out
  localparam int TAIL_CYCLES  = 60;     // final settle after the last result drains
  localparam int CYCLE_LIMIT  = 400000;
  localparam int RANDOM_ITEMS = 800;
  localparam logic [2:0] ADDR_WINDOW_LENGTH = 3'd0;

  // one expected result, as carried on out_tdata
  typedef struct packed {
    logic signed [SAMPLE_W-1:0] sample;
    logic signed [MEAN_W-1:0]   mean;
  } avg_result_t;

  // --------------------------------------------------------------------------
  // Scoreboard: own copy of the ring, write pointer and window length.
  // note_input() predicts one result per accepted transaction,
  // check_result() compares the oldest prediction with what came out.
  // --------------------------------------------------------------------------
  class temp_avg_scoreboard;
    logic signed [SAMPLE_W-1:0] ring [RING_DEPTH];
    int unsigned                slot;
    bit                         primed;
    logic [WLEN_W-1:0]          wlen;
    avg_result_t                expected_q [$];
    int                         errors;
    int                         checked;

    function new();
      foreach (ring[i]) ring[i] = '0;
      slot    = 0;
      primed  = 0;
      wlen    = WLEN_RESET;
      errors  = 0;
      checked = 0;
    endfunction

    function void set_window(logic [WLEN_W-1:0] v);
      wlen = v;
    endfunction

    function int pending();
      return expected_q.size();
    endfunction

    function void note_input(logic [7:0] lo, logic [7:0] hi, logic [7:0] res);
      logic [SAMPLE_W-1:0] raw;
      int unsigned         eff_len;
      int unsigned         s;
      longint              sum;
      longint              mean;
      avg_result_t         r;
      raw = {hi, lo};
      // clear the bits the sensor leaves undefined at lower resolution
      case (res[6:5])
        RES_9BIT:  raw[2:0] = 3'b000;
        RES_10BIT: raw[1:0] = 2'b00;
        RES_11BIT: raw[0]   = 1'b0;
        default:   raw      = raw;
      endcase
      // first sample after reset seeds the whole ring
      if (!primed) begin
        foreach (ring[i]) ring[i] = raw;
        primed = 1;
      end
      ring[slot] = raw;
      // zero counts as one, anything above the ring depth saturates
      eff_len = (wlen == 0) ? 1 : ((wlen > RING_DEPTH) ? RING_DEPTH : wlen);
      sum = 0;
      s   = slot;
      for (int i = 0; i < eff_len; i++) begin
        sum += longint'(ring[s]);
        s = (s == 0) ? RING_DEPTH - 1 : s - 1;
      end
      slot = (slot + 1 >= RING_DEPTH) ? 0 : slot + 1;
      mean = (sum * 16) / longint'(eff_len);   // truncates toward zero
      r.sample = raw;
      r.mean   = mean[MEAN_W-1:0];
      expected_q.insert(expected_q.size(), r);
    endfunction

    function void check_result(logic [39:0] d);
      avg_result_t exp_r;
      if (expected_q.size() == 0) begin
        $error("unexpected result transaction: tdata=%h", d);
        errors++;
        return;
      end
      exp_r = expected_q[0];
      expected_q.delete(0);
      checked++;
      if (d[15:0] !== exp_r.sample) begin
        $error("sample_sixteenths: expected %0d, got %0d",
               exp_r.sample, $signed(d[15:0]));
        errors++;
      end
      if (d[35:16] !== exp_r.mean) begin
        $error("mean_256ths: expected %0d, got %0d", exp_r.mean, $signed(d[35:16]));
        errors++;
      end
      if (d[39:36] !== 4'h0) begin
        $error("tdata pad: expected 0, got %h", d[39:36]);
        errors++;
      end
    endfunction
  endclass

  // --------------------------------------------------------------------------
  // DUT signals; the bench-driven inputs start at known values from time zero
  // --------------------------------------------------------------------------
  logic        clk         = 1'b0;
  logic        rst_n       = 1'b0;
  logic        in_tvalid   = 1'b0;
  logic        in_tready;
  logic [23:0] in_tdata    = '0;   // [7:0] low byte, [15:8] high byte, [23:16] res byte
  logic        out_tvalid;
  logic        out_tready  = 1'b0;
  logic [39:0] out_tdata;          // [15:0] sample, [35:16] mean, [39:36] zero
  logic        cfg_psel    = 1'b0;
  logic        cfg_penable = 1'b0;
  logic        cfg_pwrite  = 1'b0;
  logic [2:0]  cfg_paddr   = '0;
  logic [31:0] cfg_pwdata  = '0;
  logic [31:0] cfg_prdata;
  logic        cfg_pready;

  temp_avg_scoreboard sb;
  int send_idle_pct  = 0;   // chance in 100 the sender idles a cycle
  int recv_stall_pct = 0;   // chance in 100 the receiver stalls a cycle
  int items_sent     = 0;
  int window_writes  = 0;
  int cycle_count    = 0;

  temp_sensor_decode_moving_average uut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready)
  );

  always begin
    #CLK_HALF_NS clk = 1'b1;
    #CLK_HALF_NS clk = 1'b0;
  end

  // watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("[temp_sensor_decode_moving_average] ERROR");
      $finish;
    end
  end

  // receiver backpressure, redrawn every falling edge
  always @(negedge clk) begin
    out_tready <= (recv_stall_pct == 0) || ($urandom_range(99) >= recv_stall_pct);
  end

  // result monitor: a transaction completes at the rising edge
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) sb.check_result(out_tdata);
  end

  // --------------------------------------------------------------------------
  // Drivers. All tasks are entered and left at a falling edge.
  // --------------------------------------------------------------------------

  // one input transaction with an optional random lead-in gap
  task automatic send_bytes(input logic [7:0] lo, input logic [7:0] hi,
                            input logic [7:0] res);
    while (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
      in_tvalid = 1'b0;
      @(negedge clk);
    end
    in_tvalid = 1'b1;
    in_tdata  = {res, hi, lo};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    sb.note_input(lo, hi, res);
    items_sent++;
    @(negedge clk);
  endtask

  // stop sending and let every outstanding result drain
  task automatic wait_results_drained(input int settle);
    in_tvalid = 1'b0;
    while (sb.pending() != 0) @(negedge clk);
    repeat (settle) @(negedge clk);
  endtask

  // APB write of window_length followed by a read-back check
  task automatic write_window_length(input logic [WLEN_W-1:0] v);
    cfg_psel   = 1'b1;
    cfg_pwrite = 1'b1;
    cfg_paddr  = ADDR_WINDOW_LENGTH;
    cfg_pwdata = {27'($urandom_range(0, 32'h07FF_FFFF)), v};  // upper bits are don't-care
    @(negedge clk);
    cfg_penable = 1'b1;
    @(posedge clk);
    while (!cfg_pready) @(posedge clk);
    sb.set_window(v);
    window_writes++;
    @(negedge clk);
    cfg_penable = 1'b0;
    cfg_pwrite  = 1'b0;
    @(negedge clk);
    cfg_penable = 1'b1;
    @(posedge clk);
    while (!cfg_pready) @(posedge clk);
    if (cfg_prdata !== {27'd0, v}) begin
      $error("window_length readback: expected %0d, got %0d", v, cfg_prdata);
      sb.errors++;
    end
    @(negedge clk);
    cfg_psel    = 1'b0;
    cfg_penable = 1'b0;
  endtask

  // random reading: mostly in the sensor's real range, some near the
  // 16-bit extremes, the rest fully random bytes
  task automatic send_random_reading();
    int          pick;
    int          v;
    logic [15:0] t;
    logic [7:0]  res;
    pick = $urandom_range(99);
    if (pick < 65) begin
      v   = int'($urandom_range(0, 2880)) - 880;   // -55 .. +125 C
      t   = v[15:0];
      res = {1'b0, 2'($urandom_range(3)), 5'h1F};
    end else if (pick < 75) begin
      v   = int'($urandom_range(0, 15));
      t   = $urandom_range(1) ? 16'h7FFF - 16'(v) : 16'h8000 + 16'(v);
      res = 8'($urandom);
    end else begin
      t   = 16'($urandom);
      res = 8'($urandom);
    end
    send_bytes(t[7:0], t[15:8], res);
  endtask

  // --------------------------------------------------------------------------
  // Test sequence
  // --------------------------------------------------------------------------
  int win_plan [8] = '{16, 1, 9, 31, 0, 17, 5, 12};
  int send_plan [4] = '{0, 57, 0, 6};
  int recv_plan [4] = '{0, 0, 57, 6};

  initial begin
    sb = new();
    repeat (RESET_CYCLES) @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    // directed: reset window of 4, first sample seeds the ring
    send_bytes(8'h91, 8'h01, 8'h7F);   // +25.0625 C, 12 bit
    send_bytes(8'hFF, 8'h7F, 8'h7F);   // most positive code
    send_bytes(8'h00, 8'h80, 8'h7F);   // most negative code
    send_bytes(8'hFF, 8'hFF, 8'h1F);   // 9 bit clears three low bits
    send_bytes(8'hFF, 8'hFF, 8'h3F);   // 10 bit
    send_bytes(8'hFF, 8'hFF, 8'h5F);   // 11 bit
    send_bytes(8'hFF, 8'hFF, 8'hFF);   // 12 bit, stray bits set
    send_bytes(8'h00, 8'h00, 8'h00);
    send_bytes(8'h5E, 8'hFE, 8'h80);   // 9 bit with bit 7 set
    wait_results_drained(IDLE_CYCLES);

    // widest window: older ring entries come back into the sum
    write_window_length(5'd16);
    send_bytes(8'h00, 8'h80, 8'h60);
    send_bytes(8'h00, 8'h80, 8'h60);
    send_bytes(8'hFF, 8'h7F, 8'h60);
    wait_results_drained(IDLE_CYCLES);
    // zero acts as one
    write_window_length(5'd0);
    send_bytes(8'h0F, 8'hFC, 8'h7F);
    send_bytes(8'h37, 8'h05, 8'h20);
    wait_results_drained(IDLE_CYCLES);
    // above the ring depth saturates
    write_window_length(5'd31);
    send_bytes(8'hA2, 8'h00, 8'h40);
    send_bytes(8'h01, 8'h80, 8'hE0);
    wait_results_drained(IDLE_CYCLES);
    write_window_length(5'd17);
    send_bytes(8'h50, 8'h05, 8'h7F);
    wait_results_drained(IDLE_CYCLES);
    write_window_length(5'd1);
    send_bytes(8'h90, 8'hFC, 8'h7F);
    wait_results_drained(IDLE_CYCLES);

    // random phases, two window settings per idling mode
    for (int ph = 0; ph < 4; ph++) begin
      send_idle_pct  = send_plan[ph];
      recv_stall_pct = recv_plan[ph];
      for (int half = 0; half < 2; half++) begin
        write_window_length(5'(win_plan[2*ph + half]));
        for (int n = 0; n < RANDOM_ITEMS / 8; n++) begin
          send_random_reading();
          // sender holds off mid-phase until everything is back
          if (n == RANDOM_ITEMS / 16) wait_results_drained(0);
        end
        wait_results_drained(IDLE_CYCLES);
      end
    end

    send_idle_pct  = 0;
    recv_stall_pct = 0;
    wait_results_drained(TAIL_CYCLES);
    if (sb.pending() != 0) begin
      $error("%0d expected results never arrived", sb.pending());
      sb.errors++;
    end

    $display("covered %0d readings, %0d results checked, %0d window_length writes",
             items_sent, sb.checked, window_writes);
    $display("all four resolutions, window 0/1/16/17/31, four idling mixes");
    if (sb.errors == 0) begin
      $display("[temp_sensor_decode_moving_average] OK");
    end else begin
      $display("[temp_sensor_decode_moving_average] ERROR");
    end
    $finish;
  end

endmodule

### temp_sensor_decode_moving_average.f
rtl/tsdma_pkg.sv
rtl/tsdma_cell.sv
rtl/tsdma_div.sv
rtl/temp_sensor_decode_moving_average.sv
sim/tb_top.sv
